### src/vrra_pkg.sv
// Shared types, widths and microcode encodings for the record ring allocator.
package vrra_pkg;

   localparam int ALIGN_BYTES = 4;
   localparam int ALIGN_SHIFT = 2;
   localparam int OFF_W       = 14;
   localparam int OFF_SPAN    = 16384;
   localparam int TEXT_W      = 14;
   localparam int LEN_W       = 15;
   localparam int BUF_W       = 15;
   localparam int HDR_W       = 7;
   localparam int DROP_W      = 13;
   localparam int SEQ_W       = 32;
   localparam int DROP_LIMIT  = 4096;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 15;

   localparam logic [BUF_W-1:0] BUF_RESET = 15'd16384;
   localparam logic [BUF_W-1:0] BUF_MIN   = 15'd64;
   localparam logic [HDR_W-1:0] HDR_RESET = 7'd24;
   localparam logic [HDR_W-1:0] HDR_MIN   = 7'd4;
   localparam logic [HDR_W-1:0] HDR_MAX   = 7'd64;
   localparam logic [OFF_W-1:0] OFF_MAX   = 14'h3FFF;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_BYTES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 1'b1;

   // datapath actions, one per control word
   localparam int ACT_W = 4;
   localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD     = 4'd1;
   localparam logic [ACT_W-1:0] ACT_RD_OLD   = 4'd2;
   localparam logic [ACT_W-1:0] ACT_RD_ZERO  = 4'd3;
   localparam logic [ACT_W-1:0] ACT_ADV_LEN  = 4'd4;
   localparam logic [ACT_W-1:0] ACT_ADV_ZERO = 4'd5;
   localparam logic [ACT_W-1:0] ACT_MARK     = 4'd6;
   localparam logic [ACT_W-1:0] ACT_PLACE    = 4'd7;
   localparam logic [ACT_W-1:0] ACT_EMIT     = 4'd8;

   // jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEVER     = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ    = 3'd2;
   localparam logic [COND_W-1:0] COND_DROP_DONE = 3'd3;
   localparam logic [COND_W-1:0] COND_NONZERO   = 3'd4;
   localparam logic [COND_W-1:0] COND_OUT_FREE  = 3'd5;

   // program step addresses
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
   localparam logic [PC_W-1:0] S_LOOP  = 4'd1;
   localparam logic [PC_W-1:0] S_TEST  = 4'd2;
   localparam logic [PC_W-1:0] S_RDZ   = 4'd3;
   localparam logic [PC_W-1:0] S_ADVZ  = 4'd4;
   localparam logic [PC_W-1:0] S_ADVL  = 4'd5;
   localparam logic [PC_W-1:0] S_MARK  = 4'd6;
   localparam logic [PC_W-1:0] S_PLACE = 4'd7;
   localparam logic [PC_W-1:0] S_EMIT  = 4'd8;
   localparam logic [PC_W-1:0] S_HOLD  = 4'd9;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } uword_type;

   typedef struct packed {
      logic [PC_W-1:0]  step;
      logic [ACT_W-1:0] act;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic drop_done;
      logic rd_nonzero;
      logic out_free;
   } flags_type;

endpackage

### src/vrra_req_if.sv
// Request channel: text length of the record to append.
interface vrra_req_if import vrra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_bytes;

   modport source (output valid, output text_bytes, input ready);
   modport sink (input valid, input text_bytes, output ready);
endinterface

### src/vrra_rsp_if.sv
// Response channel: placement result for one record.
interface vrra_rsp_if import vrra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              status;
   logic [OFF_W-1:0]  place_offset;
   logic [OFF_W-1:0]  record_length;
   logic              wrapped;
   logic [OFF_W-1:0]  marker_offset;
   logic [DROP_W-1:0] dropped;
   logic [SEQ_W-1:0]  record_seq;
   logic [OFF_W-1:0]  oldest_offset;

   modport source (output valid, output status, output place_offset, output record_length,
                   output wrapped, output marker_offset, output dropped, output record_seq,
                   output oldest_offset, input ready);
   modport sink (input valid, input status, input place_offset, input record_length,
                 input wrapped, input marker_offset, input dropped, input record_seq,
                 input oldest_offset, output ready);
endinterface

### src/vrra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vrra_ram #(
   parameter int   WIDTH = 14,
   parameter int   DEPTH = 4096,
   localparam int  AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/vrra_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module vrra_seq import vrra_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         S_IDLE:  w = '{act: ACT_LOAD,     cond: COND_NO_REQ,    target: S_IDLE};
         S_LOOP:  w = '{act: ACT_RD_OLD,   cond: COND_DROP_DONE, target: S_MARK};
         S_TEST:  w = '{act: ACT_NONE,     cond: COND_NONZERO,   target: S_ADVL};
         S_RDZ:   w = '{act: ACT_RD_ZERO,  cond: COND_NEVER,     target: S_IDLE};
         S_ADVZ:  w = '{act: ACT_ADV_ZERO, cond: COND_ALWAYS,    target: S_LOOP};
         S_ADVL:  w = '{act: ACT_ADV_LEN,  cond: COND_ALWAYS,    target: S_LOOP};
         S_MARK:  w = '{act: ACT_MARK,     cond: COND_NEVER,     target: S_IDLE};
         S_PLACE: w = '{act: ACT_PLACE,    cond: COND_NEVER,     target: S_IDLE};
         S_EMIT:  w = '{act: ACT_EMIT,     cond: COND_OUT_FREE,  target: S_IDLE};
         S_HOLD:  w = '{act: ACT_NONE,     cond: COND_ALWAYS,    target: S_EMIT};
         default: w = '{act: ACT_NONE,     cond: COND_ALWAYS,    target: S_IDLE};
      endcase
      return w;
   endfunction

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   uword_type       word;
   logic            taken;

   assign word = ucode(pc_ff);

   always_comb begin
      case (word.cond)
         COND_NEVER:     taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_NO_REQ:    taken = !flags.req_valid;
         COND_DROP_DONE: taken = flags.drop_done;
         COND_NONZERO:   taken = flags.rd_nonzero;
         COND_OUT_FREE:  taken = flags.out_free;
         default:        taken = 1'b1;
      endcase
      pc_in = taken ? word.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.step = pc_ff;
   assign ctrl.act  = word.act;

endmodule

### src/vrra_dp.sv
// Allocator datapath: settings, ring pointers, length store and result register.
module vrra_dp import vrra_pkg::*; #(
   parameter int MAX_BUFFER_BYTES = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   vrra_req_if.sink              req_chan,
   vrra_rsp_if.source            rsp_chan,
   input  ctrl_type              ctrl,
   output flags_type             flags
);

   localparam int STORE_DEPTH = MAX_BUFFER_BYTES / ALIGN_BYTES;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int WORD_W      = OFF_W - ALIGN_SHIFT;
   localparam int WIDE_W      = (AW > WORD_W) ? AW : WORD_W;
   localparam int BUF_TOP     = (MAX_BUFFER_BYTES < OFF_SPAN) ? MAX_BUFFER_BYTES : OFF_SPAN;
   localparam int SUM_W       = LEN_W + 1;

   function automatic logic [AW-1:0] word_of(input logic [OFF_W-1:0] off);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(off[OFF_W-1:ALIGN_SHIFT]);
      return wide[AW-1:0];
   endfunction

   // settings
   logic [BUF_W-1:0] buf_reg_ff;
   logic [HDR_W-1:0] hdr_reg_ff;
   logic [BUF_W-1:0] buf_clamp, buf_eff;
   logic [HDR_W-1:0] hdr_clamp, hdr_eff;

   // ring state
   logic [OFF_W-1:0] oldest_ff, next_ff;
   logic [SEQ_W-1:0] oseq_ff, nseq_ff;
   logic             w0_valid_ff;

   // per-record working registers
   logic [LEN_W-1:0]  len_ff, lh_ff;
   logic              reject_ff;
   logic [SEQ_W-1:0]  seq_out_ff;
   logic [DROP_W-1:0] drop_ff;
   logic              wrapped_ff;
   logic [OFF_W-1:0]  marker_ff, place_ff;
   logic              rd_zero_ff;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic [OFF_W-1:0]  rsp_place_ff, rsp_len_ff, rsp_marker_ff, rsp_oldest_ff;
   logic              rsp_wrapped_ff;
   logic [DROP_W-1:0] rsp_dropped_ff;
   logic [SEQ_W-1:0]  rsp_seq_ff;

   logic [LEN_W-1:0] len_sum, len_new, lh_new;
   logic             accept, out_free, need_wrap, drop_done;
   logic [BUF_W-1:0] tail, space;
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [OFF_W-1:0] wr_data, ram_q, rd_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_reg_ff <= BUF_RESET;
         hdr_reg_ff <= HDR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BUFFER_BYTES: buf_reg_ff <= csr_write_data[BUF_W-1:0];
            CSR_HEADER_BYTES: hdr_reg_ff <= csr_write_data[HDR_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp settings to their legal span and round down to whole words
   always_comb begin
      buf_clamp = buf_reg_ff;
      if (buf_reg_ff < BUF_MIN) begin
         buf_clamp = BUF_MIN;
      end else if (buf_reg_ff > BUF_W'(BUF_TOP)) begin
         buf_clamp = BUF_W'(BUF_TOP);
      end
      buf_eff = {buf_clamp[BUF_W-1:ALIGN_SHIFT], {ALIGN_SHIFT{1'b0}}};
      hdr_clamp = hdr_reg_ff;
      if (hdr_reg_ff < HDR_MIN) begin
         hdr_clamp = HDR_MIN;
      end else if (hdr_reg_ff > HDR_MAX) begin
         hdr_clamp = HDR_MAX;
      end
      hdr_eff = {hdr_clamp[HDR_W-1:ALIGN_SHIFT], {ALIGN_SHIFT{1'b0}}};
   end

   assign len_sum = LEN_W'(hdr_eff) + LEN_W'(req_chan.text_bytes) + LEN_W'(ALIGN_BYTES - 1);
   assign len_new = {len_sum[LEN_W-1:ALIGN_SHIFT], {ALIGN_SHIFT{1'b0}}};
   assign lh_new  = len_new + LEN_W'(hdr_eff);

   assign req_chan.ready = (ctrl.act == ACT_LOAD) && !reset;
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // contiguous free space ahead of the write pointer
   always_comb begin
      tail = (BUF_W'(next_ff) >= buf_eff) ? '0 : buf_eff - BUF_W'(next_ff);
      if (next_ff > oldest_ff) begin
         space = (tail > BUF_W'(oldest_ff)) ? tail : BUF_W'(oldest_ff);
      end else begin
         space = BUF_W'(oldest_ff - next_ff);
      end
   end

   assign drop_done = reject_ff || (oseq_ff == nseq_ff) ||
                      (drop_ff == DROP_W'(DROP_LIMIT)) || (space > lh_ff);
   assign need_wrap = (SUM_W'(next_ff) + SUM_W'(lh_ff)) >= SUM_W'(buf_eff);

   // length store access
   assign rd_en   = (ctrl.act == ACT_RD_OLD) || (ctrl.act == ACT_RD_ZERO);
   assign rd_addr = (ctrl.act == ACT_RD_ZERO) ? '0 : word_of(oldest_ff);
   assign wr_en   = !reject_ff &&
                    (((ctrl.act == ACT_MARK) && need_wrap) || (ctrl.act == ACT_PLACE));
   assign wr_addr = word_of(next_ff);
   assign wr_data = (ctrl.act == ACT_PLACE) ? len_ff[OFF_W-1:0] : '0;

   vrra_ram #(
      .WIDTH (OFF_W),
      .DEPTH (STORE_DEPTH)
   ) u_len_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // word zero reads as cleared until first written after reset
   assign rd_val = (rd_zero_ff && !w0_valid_ff) ? '0 : ram_q;

   assign flags.req_valid  = req_chan.valid;
   assign flags.drop_done  = drop_done;
   assign flags.rd_nonzero = (rd_val != '0);
   assign flags.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         next_ff      <= '0;
         oseq_ff      <= '0;
         nseq_ff      <= '0;
         w0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en && (wr_addr == '0)) begin
            w0_valid_ff <= 1'b1;
         end
         case (ctrl.act)
            ACT_ADV_LEN: begin
               oldest_ff <= oldest_ff + rd_val;
               oseq_ff   <= oseq_ff + 1'b1;
            end
            ACT_ADV_ZERO: begin
               oldest_ff <= rd_val;
               oseq_ff   <= oseq_ff + 1'b1;
            end
            ACT_MARK: begin
               if (!reject_ff && need_wrap) begin
                  next_ff <= '0;
               end
            end
            ACT_PLACE: begin
               if (!reject_ff) begin
                  next_ff <= next_ff + len_ff[OFF_W-1:0];
                  nseq_ff <= nseq_ff + 1'b1;
               end
            end
            default: ;
         endcase
         if ((ctrl.act == ACT_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_zero_ff <= (rd_addr == '0);
      end
      case (ctrl.act)
         ACT_LOAD: begin
            if (accept) begin
               len_ff     <= len_new;
               lh_ff      <= lh_new;
               reject_ff  <= (lh_new >= buf_eff);
               seq_out_ff <= nseq_ff;
               drop_ff    <= '0;
               wrapped_ff <= 1'b0;
               marker_ff  <= '0;
               place_ff   <= '0;
            end
         end
         ACT_ADV_LEN, ACT_ADV_ZERO: begin
            drop_ff <= drop_ff + 1'b1;
         end
         ACT_MARK: begin
            if (!reject_ff && need_wrap) begin
               wrapped_ff <= 1'b1;
               marker_ff  <= next_ff;
            end
         end
         ACT_PLACE: begin
            if (!reject_ff) begin
               place_ff <= next_ff;
            end
         end
         ACT_EMIT: begin
            if (out_free) begin
               rsp_status_ff  <= reject_ff;
               rsp_place_ff   <= place_ff;
               rsp_len_ff     <= len_ff[LEN_W-1] ? OFF_MAX : len_ff[OFF_W-1:0];
               rsp_wrapped_ff <= wrapped_ff;
               rsp_marker_ff  <= marker_ff;
               rsp_dropped_ff <= drop_ff;
               rsp_seq_ff     <= seq_out_ff;
               rsp_oldest_ff  <= oldest_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.place_offset  = rsp_place_ff;
   assign rsp_chan.record_length = rsp_len_ff;
   assign rsp_chan.wrapped       = rsp_wrapped_ff;
   assign rsp_chan.marker_offset = rsp_marker_ff;
   assign rsp_chan.dropped       = rsp_dropped_ff;
   assign rsp_chan.record_seq    = rsp_seq_ff;
   assign rsp_chan.oldest_offset = rsp_oldest_ff;

endmodule

### src/variable_record_ring_allocator.sv
// Top level of the variable-length record ring allocator.
//
// Each transfer on req_chan carries the text length of one log record. The
// block pads header plus text to whole words, drops the oldest records until
// there is room, writes a wrap marker when the record would run past the
// buffer end, and returns exactly one transfer on rsp_chan: placement offset,
// padded length, wrap marker offset, drop count, sequence number and oldest
// offset. A record that cannot fit even in an empty buffer comes back with
// status set and changes nothing.
// Sequence: after a request transfer the block walks the drops, then runs
// its wrap marker, placement and output steps and takes the next request in
// its idle step; requests are taken one at a time. A dropped record costs one
// read of the length store, a dropped wrap marker two.
// A stalled receiver holds the response register; the sequencer waits in its
// output and hold steps and takes no request until the register is free.
// Reset clears the ring pointers and sequence numbers, sets buffer_bytes to
// 16384 and header_bytes to 24, and marks word 0 of the length store as
// cleared; no clearing pass is run. Write csr_ registers only while idle.
module variable_record_ring_allocator import vrra_pkg::*; #(
   parameter int MAX_BUFFER_BYTES = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   vrra_req_if.sink              req_chan,
   vrra_rsp_if.source            rsp_chan
);

   ctrl_type  ctrl;
   flags_type flags;

   vrra_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   vrra_dp #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .ctrl             (ctrl),
      .flags            (flags)
   );

   // a taken request always starts the drop walk
   a_accept_to_loop: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (ctrl.step == S_LOOP))
      else $error("request transfer not followed by drop walk");

   // a free output step always produces a response
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      ((ctrl.act == ACT_EMIT) && flags.out_free) |=> rsp_chan.valid)
      else $error("output step did not raise response valid");

   a_drop_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.dropped <= DROP_W'(DROP_LIMIT)))
      else $error("drop count beyond limit");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status) |->
         (!rsp_chan.wrapped && (rsp_chan.dropped == '0) && (rsp_chan.place_offset == '0)))
      else $error("rejected record shows placement side effects");

endmodule

### tb/testbench.sv
// Self-checking testbench for the variable-length record ring allocator.
`timescale 1ns / 100ps

module testbench;
   import vrra_pkg::*;

   localparam int IDLE_PCT        = 24;
   localparam int WATCHDOG_LIMIT  = 100000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int CALM_PHASE      = 5;
   localparam int STORE_WORDS     = OFF_SPAN / ALIGN_BYTES;
   localparam int TEXT_MAX        = (1 << TEXT_W) - 1;
   localparam int DIRECTED_ROWS   = 29;

   typedef struct packed {
      logic              status;
      logic [OFF_W-1:0]  place_offset;
      logic [OFF_W-1:0]  record_length;
      logic              wrapped;
      logic [OFF_W-1:0]  marker_offset;
      logic [DROP_W-1:0] dropped;
      logic [SEQ_W-1:0]  record_seq;
      logic [OFF_W-1:0]  oldest_offset;
   } placement_type;

   typedef enum {ROW_APPEND, ROW_APPEND_TYPED, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic [TEXT_W-1:0]     text;
      placement_type         want;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   vrra_req_if req_if ();
   vrra_rsp_if rsp_if ();

   variable_record_ring_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if)
   );

   always #5 clock = ~clock;

   // ring state as the block should hold it
   logic [BUF_W-1:0]  buffer_reg      = BUF_RESET;
   logic [HDR_W-1:0]  header_reg      = HDR_RESET;
   logic [OFF_W-1:0]  oldest_off      = '0;
   logic [OFF_W-1:0]  next_off        = '0;
   logic [SEQ_W-1:0]  oldest_sequence = '0;
   logic [SEQ_W-1:0]  next_sequence   = '0;
   bit   [15:0]       word_len  [0:STORE_WORDS-1];
   bit                word_seen [0:STORE_WORDS-1];

   placement_type pending_placements[$];
   row_type       directed_rows [0:DIRECTED_ROWS-1];

   bit calm = 1'b0;
   int failures, quiet_cycles, requests_sent, register_writes;
   int placed_count, rejected_count, wrap_count, dropped_total;

   function automatic bit idle_roll();
      return !calm && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic int unsigned usable_buffer();
      int unsigned b;
      b = buffer_reg;
      if (b < BUF_MIN) b = BUF_MIN;
      if (b > OFF_SPAN) b = OFF_SPAN;
      return b - (b % ALIGN_BYTES);
   endfunction

   function automatic int unsigned header_size();
      int unsigned h;
      h = header_reg;
      if (h < HDR_MIN) h = HDR_MIN;
      if (h > HDR_MAX) h = HDR_MAX;
      return h - (h % ALIGN_BYTES);
   endfunction

   function automatic int unsigned word_index(input int unsigned off);
      return (off / ALIGN_BYTES) % STORE_WORDS;
   endfunction

   // Work out one append. With commit low only the drop walk is run, to find
   // out whether it would touch a length word that was never written.
   function automatic placement_type model_append(input logic [TEXT_W-1:0] text,
                                                  input bit commit, output bit reads_known);
      placement_type res;
      int unsigned bsz, hsz, len, oldest, space, tail, drops, w;
      logic [SEQ_W-1:0] oseq;
      bsz = usable_buffer();
      hsz = header_size();
      len = (hsz + text + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
      res = '0;
      reads_known = 1'b1;
      if (len + hsz >= bsz) begin
         res.status        = 1'b1;
         res.record_length = (len > OFF_MAX) ? OFF_MAX : len[OFF_W-1:0];
         res.record_seq    = next_sequence;
         res.oldest_offset = oldest_off;
         if (commit) rejected_count++;
         return res;
      end
      oldest = oldest_off;
      oseq   = oldest_sequence;
      drops  = 0;
      while (oseq != next_sequence && drops < DROP_LIMIT) begin
         if (next_off > oldest) begin
            tail  = (next_off >= bsz) ? 0 : bsz - next_off;
            space = (tail > oldest) ? tail : oldest;
         end else begin
            space = oldest - next_off;
         end
         if (space > len + hsz) break;
         w = word_index(oldest);
         // word 0 is cleared at reset, so a wrap marker always reads known data
         if (!word_seen[w]) reads_known = 1'b0;
         if (word_len[w] == 0) oldest = word_len[0] & OFF_MAX;
         else oldest = (oldest + word_len[w]) & OFF_MAX;
         oseq++;
         drops++;
      end
      if (!commit) return res;
      oldest_off      = oldest[OFF_W-1:0];
      oldest_sequence = oseq;
      if (next_off + len + hsz >= bsz) begin
         w = word_index(next_off);
         word_len[w]       = '0;
         word_seen[w]      = 1'b1;
         res.wrapped       = 1'b1;
         res.marker_offset = next_off;
         next_off          = '0;
         wrap_count++;
      end
      w = word_index(next_off);
      word_len[w]       = len[15:0];
      word_seen[w]      = 1'b1;
      res.place_offset  = next_off;
      res.record_length = len[OFF_W-1:0];
      res.dropped       = drops[DROP_W-1:0];
      res.record_seq    = next_sequence;
      res.oldest_offset = oldest_off;
      next_off          = next_off + len[OFF_W-1:0];
      next_sequence++;
      placed_count++;
      dropped_total += drops;
      return res;
   endfunction

   // Swap a text length whose drop walk would read an unwritten length word.
   function automatic logic [TEXT_W-1:0] pick_safe(input logic [TEXT_W-1:0] text);
      placement_type probe;
      bit known;
      probe = model_append(text, 1'b0, known);
      if (known) return text;
      // the shortest record needs the fewest drops
      probe = model_append('0, 1'b0, known);
      if (known) return '0;
      // far too large for any buffer: rejected before any read
      return TEXT_MAX;
   endfunction

   function automatic row_type append_row(input int text);
      row_type r;
      r      = '{default: '0, kind: ROW_APPEND};
      r.text = TEXT_W'(text);
      return r;
   endfunction

   function automatic row_type typed_row(input int text, input int status, input int place,
                                         input int length, input int seq, input int oldest);
      row_type r;
      r                    = '{default: '0, kind: ROW_APPEND_TYPED};
      r.text               = TEXT_W'(text);
      r.want.status        = 1'(status);
      r.want.place_offset  = OFF_W'(place);
      r.want.record_length = OFF_W'(length);
      r.want.record_seq    = SEQ_W'(seq);
      r.want.oldest_offset = OFF_W'(oldest);
      return r;
   endfunction

   function automatic row_type csr_row(input logic [CSR_IDX_W-1:0] index,
                                       input logic [CSR_DATA_W-1:0] data);
      row_type r;
      r       = '{default: '0, kind: ROW_CSR};
      r.index = index;
      r.data  = data;
      return r;
   endfunction

   // Present one record until it transfers, then idle at random.
   task automatic drive_item(input logic [TEXT_W-1:0] text, input bit typed,
                             input placement_type want);
      placement_type predicted;
      bit known;
      csr_write_enable  <= 1'b0;
      req_if.valid      <= 1'b1;
      req_if.text_bytes <= text;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = model_append(text, 1'b1, known);
      pending_placements.push_back(typed ? want : predicted);
      requests_sent++;
      while (idle_roll()) begin
         req_if.valid      <= 1'b0;
         req_if.text_bytes <= TEXT_W'($urandom);
         @(posedge clock);
      end
   endtask

   // Hold the request side until every placement has come back.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      if (index == CSR_BUFFER_BYTES) buffer_reg = data;
      else header_reg = data[HDR_W-1:0];
      register_writes++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= !idle_roll();
   end

   always @(posedge clock) begin : rsp_monitor
      placement_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_placements.size() == 0) begin
            $display("%0t: placement transfer with none outstanding, seq %0d",
                     $time, rsp_if.record_seq);
            failures++;
         end else begin
            want = pending_placements.pop_front();
            check_field("status", want.status, rsp_if.status);
            check_field("place_offset", want.place_offset, rsp_if.place_offset);
            check_field("record_length", want.record_length, rsp_if.record_length);
            check_field("wrapped", want.wrapped, rsp_if.wrapped);
            check_field("marker_offset", want.marker_offset, rsp_if.marker_offset);
            check_field("dropped", want.dropped, rsp_if.dropped);
            check_field("record_seq", want.record_seq, rsp_if.record_seq);
            check_field("oldest_offset", want.oldest_offset, rsp_if.oldest_offset);
         end
      end
   end

   // count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int unsigned room, roll, pick;
      logic [CSR_DATA_W-1:0] raw_buf, raw_hdr;
      req_if.valid      <= 1'b0;
      req_if.text_bytes <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= '0;
      csr_write_data    <= '0;
      word_seen[0] = 1'b1;

      directed_rows = '{
         typed_row(0, 0, 0, 24, 0, 0),
         typed_row(16383, 1, 0, 16383, 1, 0),   // longest text: length saturates
         typed_row(1, 0, 24, 28, 1, 0),         // pad to a whole word
         append_row(16332),                     // largest fit: drop everything, wrap
         typed_row(16333, 1, 0, 16360, 3, 52),  // one word over the limit
         append_row(0),                         // wrap while records are held
         append_row(4),                         // drop through a wrap marker
         csr_row(CSR_BUFFER_BYTES, 15'd0),      // clamps up to the smallest buffer
         csr_row(CSR_HEADER_BYTES, 15'd0),
         append_row(0),
         append_row(55),
         append_row(51),
         append_row(3),
         csr_row(CSR_HEADER_BYTES, 15'd127),    // clamps down to the largest header
         append_row(0),
         csr_row(CSR_BUFFER_BYTES, 15'h7FFF),
         append_row(0),
         append_row(16252),
         csr_row(CSR_HEADER_BYTES, 15'd63),     // rounds down to a word
         csr_row(CSR_BUFFER_BYTES, 15'd16383),
         append_row(2),
         append_row(16259),
         append_row(16255),
         csr_row(CSR_BUFFER_BYTES, 15'd200),    // offsets now lie past the buffer end
         csr_row(CSR_HEADER_BYTES, 15'h7F84),   // upper bits are ignored
         append_row(10),
         append_row(16383),
         csr_row(CSR_BUFFER_BYTES, 15'd16384),
         csr_row(CSR_HEADER_BYTES, 15'd24)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         case (directed_rows[row].kind)
            ROW_CSR: begin
               settle();
               csr_write(directed_rows[row].index, directed_rows[row].data);
            end
            ROW_APPEND_TYPED: begin
               drive_item(directed_rows[row].text, 1'b1, directed_rows[row].want);
            end
            default: begin
               drive_item(pick_safe(directed_rows[row].text), 1'b0, '0);
            end
         endcase
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               raw_buf = BUF_RESET;
               raw_hdr = {8'd0, HDR_RESET};
            end
            1: begin
               raw_buf = 15'd0;
               raw_hdr = 15'd4;
            end
            2: begin
               // word-sized records give long drop runs
               raw_buf = 15'h7FFF;
               raw_hdr = 15'd0;
            end
            3: begin
               raw_buf = 15'd16383;
               raw_hdr = 15'd127;
            end
            default: begin
               roll = $urandom_range(99);
               if (roll < 50) raw_buf = CSR_DATA_W'($urandom_range(64, 2048));
               else if (roll < 75) raw_buf = CSR_DATA_W'($urandom_range(2049, 16384));
               else raw_buf = CSR_DATA_W'($urandom_range(0, 32767));
               raw_hdr = CSR_DATA_W'($urandom_range(0, 32767));
            end
         endcase
         settle();
         csr_write(CSR_BUFFER_BYTES, raw_buf);
         csr_write(CSR_HEADER_BYTES, raw_hdr);
         calm = (phase == CALM_PHASE);
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            // texts up to about room still fit an empty buffer
            room = (usable_buffer() > 2 * header_size()) ?
                   usable_buffer() - 2 * header_size() : 0;
            roll = $urandom_range(99);
            if (roll < 55) pick = $urandom_range(0, room / 16 + 3);
            else if (roll < 75) pick = $urandom_range(0, room + 3);
            else if (roll < 87) pick = ((room > 8) ? room - 8 : 0) + $urandom_range(0, 16);
            else if (roll < 95) pick = $urandom_range(0, TEXT_MAX);
            else pick = $urandom_range(1) ? TEXT_MAX : 0;
            if (pick > TEXT_MAX) pick = TEXT_MAX;
            drive_item(pick_safe(pick[TEXT_W-1:0]), 1'b0, '0);
         end
      end
      calm = 1'b0;

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d records sent, %0d placed, %0d rejected, %0d wrap markers",
               requests_sent, placed_count, rejected_count, wrap_count);
      $display("summary: %0d old records dropped across %0d register writes",
               dropped_total, register_writes);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### variable_record_ring_allocator.f
src/vrra_pkg.sv
src/vrra_req_if.sv
src/vrra_rsp_if.sv
src/vrra_ram.sv
src/vrra_seq.sv
src/vrra_dp.sv
src/variable_record_ring_allocator.sv
tb/testbench.sv
